### rtl/fmrb_pkg.sv
// ============================================================================
// fmrb_pkg
// Shared types, constants and ring-pointer helpers for the framed message
// ring buffer.
// ============================================================================
package fmrb_pkg;

    localparam int BUF_DEPTH   = 512;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int DIST_W      = ADDR_W + 1;
    localparam int MIN_FREE    = 34;
    localparam int MAX_DATA    = 31;
    localparam int FRAME_EXTRA = 2;
    localparam int REM_MAX     = MAX_DATA + FRAME_EXTRA;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        REQ_WBEGIN = 3'd0,
        REQ_WBYTE  = 3'd1,
        REQ_WEND   = 3'd2,
        REQ_RBEGIN = 3'd3,
        REQ_RBYTE  = 3'd4,
        REQ_REND   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DROP  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        DP_NONE        = 4'd0,
        DP_WBEGIN      = 4'd1,
        DP_WCLOSE      = 4'd2,
        DP_WBYTE       = 4'd3,
        DP_WEND_LEN    = 4'd4,
        DP_WEND_SUM    = 4'd5,
        DP_RBEGIN_ADDR = 4'd6,
        DP_RBEGIN_FIN  = 4'd7,
        DP_RBYTE_ADDR  = 4'd8,
        DP_RBYTE_FIN   = 4'd9,
        DP_REND        = 4'd10
    } t_dp_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        t_dp_op  op;
        logic    load;
        t_status res_status;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        t_req req;
        logic open;
        logic count_full;
        logic no_room;
        logic empty;
        logic rem_zero;
    } t_flags;

    function automatic t_addr ring_next(input t_addr p);
        return (p == t_addr'(BUF_DEPTH - 1)) ? '0 : p + t_addr'(1);
    endfunction

    // Distance going forward from one slot to another, modulo the depth.
    function automatic logic [DIST_W-1:0] ring_dist(input t_addr from, input t_addr to);
        logic [DIST_W-1:0] d;
        if (to >= from) begin
            d = {1'b0, to} - {1'b0, from};
        end else begin
            d = {1'b0, to} + DIST_W'(BUF_DEPTH) - {1'b0, from};
        end
        return d;
    endfunction

    // Adds a small offset (below 64) to a slot, wrapping once at most.
    function automatic t_addr ring_add(input t_addr p, input logic [5:0] n);
        logic [DIST_W-1:0] s;
        s = {1'b0, p} + {{(DIST_W-6){1'b0}}, n};
        if (s >= DIST_W'(BUF_DEPTH)) begin
            s = s - DIST_W'(BUF_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

### rtl/fmrb_ctrl.sv
// ============================================================================
// fmrb_ctrl
// Request sequencer: decodes each transaction against the buffer flags and
// steps the datapath through decode and, where needed, a finishing state.
// ============================================================================
module fmrb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output logic           o_done,
    input  fmrb_pkg::t_flags i_flags,
    output fmrb_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_DECODE     = 5'b00010,
        S_WEND_SUM   = 5'b00100,
        S_RBEGIN_FIN = 5'b01000,
        S_RBYTE_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.op         = fmrb_pkg::DP_NONE;
        o_cmd.load       = 1'b0;
        o_cmd.res_status = fmrb_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state    = S_IDLE;
                o_cmd.load = 1'b1;
                case (i_flags.req)
                    fmrb_pkg::REQ_WBEGIN: begin
                        if (i_flags.no_room) begin
                            o_cmd.op         = fmrb_pkg::DP_WCLOSE;
                            o_cmd.res_status = fmrb_pkg::ST_FULL;
                        end else begin
                            o_cmd.op = fmrb_pkg::DP_WBEGIN;
                        end
                    end
                    fmrb_pkg::REQ_WBYTE: begin
                        if (!i_flags.open || i_flags.count_full) begin
                            o_cmd.res_status = fmrb_pkg::ST_DROP;
                        end else begin
                            o_cmd.op = fmrb_pkg::DP_WBYTE;
                        end
                    end
                    fmrb_pkg::REQ_WEND: begin
                        if (!i_flags.open) begin
                            o_cmd.res_status = fmrb_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.op   = fmrb_pkg::DP_WEND_LEN;
                            o_cmd.load = 1'b0;
                            n_state    = S_WEND_SUM;
                        end
                    end
                    fmrb_pkg::REQ_RBEGIN: begin
                        if (i_flags.empty) begin
                            o_cmd.res_status = fmrb_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.op   = fmrb_pkg::DP_RBEGIN_ADDR;
                            o_cmd.load = 1'b0;
                            n_state    = S_RBEGIN_FIN;
                        end
                    end
                    fmrb_pkg::REQ_RBYTE: begin
                        if (i_flags.rem_zero) begin
                            o_cmd.res_status = fmrb_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.op   = fmrb_pkg::DP_RBYTE_ADDR;
                            o_cmd.load = 1'b0;
                            n_state    = S_RBYTE_FIN;
                        end
                    end
                    fmrb_pkg::REQ_REND: begin
                        o_cmd.op = fmrb_pkg::DP_REND;
                    end
                    default: begin
                        o_cmd.op = fmrb_pkg::DP_NONE;
                    end
                endcase
            end
            S_WEND_SUM: begin
                o_cmd.op   = fmrb_pkg::DP_WEND_SUM;
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_RBEGIN_FIN: begin
                o_cmd.op   = fmrb_pkg::DP_RBEGIN_FIN;
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_RBYTE_FIN: begin
                o_cmd.op   = fmrb_pkg::DP_RBYTE_FIN;
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.load;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    // The result strobe is only ever shown while the sequencer is in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // Every finishing state is entered straight from decode.
    a_fin_from_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WEND_SUM || r_state == S_RBEGIN_FIN || r_state == S_RBYTE_FIN)
        |-> ($past(r_state) == S_DECODE))
        else $error("finishing state not entered from decode");

    // An accepted transaction always produces a result strobe.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##[2:3] r_done)
        else $error("accepted transaction gave no result");

endmodule

### rtl/fmrb_dp.sv
// ============================================================================
// fmrb_dp
// Buffer datapath: frame store memory, write and read pointers, running
// checksum and result registers.
// ============================================================================
module fmrb_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_req_type,
    input  logic [7:0]        i_data_in,
    input  logic              i_is_text,
    input  fmrb_pkg::t_cmd    i_cmd,
    output fmrb_pkg::t_flags  o_flags,
    output logic [1:0]        o_status,
    output logic [5:0]        o_frame_length,
    output logic [7:0]        o_byte_out,
    output logic              o_last_byte
);

    logic [7:0] mem [fmrb_pkg::BUF_DEPTH];

    fmrb_pkg::t_req  r_req;
    logic [7:0]      r_data;
    logic            r_text;
    logic [7:0]      r_rdata;

    fmrb_pkg::t_addr r_commit_head, r_write_position, r_release_head, r_read_position;
    logic [5:0]      r_write_count, r_read_remaining;
    logic [7:0]      r_write_sum;
    logic            r_write_open;

    logic [1:0]      r_status;
    logic [5:0]      r_frame_length;
    logic [7:0]      r_byte_out;
    logic            r_last_byte;

    logic            wr_en, rd_en;
    fmrb_pkg::t_addr wr_addr, rd_addr, rend_pos;
    logic [7:0]      wr_data, len_byte;
    logic [5:0]      rem_dec, rbegin_len;

    assign len_byte   = {r_text, 2'b00, r_write_count[4:0]};
    assign rem_dec    = r_read_remaining - 6'd1;
    assign rbegin_len = {1'b0, r_rdata[4:0]} + 6'(fmrb_pkg::FRAME_EXTRA);
    assign rend_pos   = (r_read_remaining != 6'd0)
                      ? fmrb_pkg::ring_add(r_read_position, rem_dec) : r_read_position;

    always_comb begin
        o_flags.req        = r_req;
        o_flags.open       = r_write_open;
        o_flags.count_full = (r_write_count >= 6'(fmrb_pkg::MAX_DATA));
        o_flags.no_room    = (fmrb_pkg::ring_dist(r_commit_head, r_release_head)
                              < fmrb_pkg::DIST_W'(fmrb_pkg::MIN_FREE));
        o_flags.empty      = (fmrb_pkg::ring_dist(r_release_head, r_commit_head)
                              <= fmrb_pkg::DIST_W'(1));
        o_flags.rem_zero   = (r_read_remaining == 6'd0);
    end

    // Memory port control.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_write_position;
        wr_data = r_data;
        rd_en   = 1'b0;
        rd_addr = r_read_position;
        case (i_cmd.op)
            fmrb_pkg::DP_WBYTE: begin
                wr_en = 1'b1;
            end
            fmrb_pkg::DP_WEND_LEN: begin
                wr_en   = 1'b1;
                wr_addr = r_commit_head;
                wr_data = len_byte;
            end
            fmrb_pkg::DP_WEND_SUM: begin
                wr_en   = 1'b1;
                wr_data = 8'd0 - r_write_sum;
            end
            fmrb_pkg::DP_RBEGIN_ADDR: begin
                rd_en   = 1'b1;
                rd_addr = fmrb_pkg::ring_next(r_release_head);
            end
            fmrb_pkg::DP_RBYTE_ADDR: begin
                rd_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Captured request and result registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= fmrb_pkg::t_req'(i_req_type);
            r_data <= i_data_in;
            r_text <= i_is_text;
        end
        if (i_cmd.load) begin
            r_status       <= i_cmd.res_status;
            r_frame_length <= (i_cmd.op == fmrb_pkg::DP_RBEGIN_FIN) ? rbegin_len : 6'd0;
            r_byte_out     <= (i_cmd.op == fmrb_pkg::DP_RBYTE_FIN) ? r_rdata : 8'd0;
            r_last_byte    <= (i_cmd.op == fmrb_pkg::DP_RBYTE_FIN) && (rem_dec == 6'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit_head    <= fmrb_pkg::t_addr'(1);
            r_write_position <= '0;
            r_write_count    <= '0;
            r_write_sum      <= '0;
            r_write_open     <= 1'b0;
            r_release_head   <= '0;
            r_read_position  <= '0;
            r_read_remaining <= '0;
        end else begin
            case (i_cmd.op)
                fmrb_pkg::DP_WBEGIN: begin
                    r_write_position <= fmrb_pkg::ring_next(r_commit_head);
                    r_write_count    <= '0;
                    r_write_sum      <= '0;
                    r_write_open     <= 1'b1;
                end
                fmrb_pkg::DP_WCLOSE: begin
                    r_write_open <= 1'b0;
                end
                fmrb_pkg::DP_WBYTE: begin
                    r_write_position <= fmrb_pkg::ring_next(r_write_position);
                    r_write_count    <= r_write_count + 6'd1;
                    r_write_sum      <= r_write_sum + r_data;
                end
                fmrb_pkg::DP_WEND_LEN: begin
                    r_write_sum <= r_write_sum + len_byte;
                end
                fmrb_pkg::DP_WEND_SUM: begin
                    r_commit_head <= fmrb_pkg::ring_next(r_write_position);
                    r_write_open  <= 1'b0;
                end
                fmrb_pkg::DP_RBEGIN_ADDR: begin
                    r_read_position <= fmrb_pkg::ring_next(r_release_head);
                end
                fmrb_pkg::DP_RBEGIN_FIN: begin
                    r_read_remaining <= rbegin_len;
                end
                fmrb_pkg::DP_RBYTE_FIN: begin
                    r_read_remaining <= rem_dec;
                    if (rem_dec != 6'd0) begin
                        r_read_position <= fmrb_pkg::ring_next(r_read_position);
                    end
                end
                fmrb_pkg::DP_REND: begin
                    r_read_position  <= rend_pos;
                    r_read_remaining <= '0;
                    r_release_head   <= rend_pos;
                end
                default: begin
                    r_write_open <= r_write_open;
                end
            endcase
        end
    end

    assign o_status       = r_status;
    assign o_frame_length = r_frame_length;
    assign o_byte_out     = r_byte_out;
    assign o_last_byte    = r_last_byte;

    // The open frame never holds more than the data limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_count <= 6'(fmrb_pkg::MAX_DATA))
        else $error("write count above limit");

    // Bytes left to read never exceed a full frame.
    a_rem_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_remaining <= 6'(fmrb_pkg::REM_MAX))
        else $error("read remaining above frame size");

    // A commit closes the frame and moves the head past its checksum slot.
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fmrb_pkg::DP_WEND_SUM)
        |=> (!r_write_open && r_commit_head == fmrb_pkg::ring_next($past(r_write_position))))
        else $error("commit did not close the frame");

endmodule

### rtl/framed_message_ring_buffer.sv
// ============================================================================
// framed_message_ring_buffer
// Circular store of outgoing messages kept as length-prefixed, checksummed
// frames, driven by one request transaction at a time.
// ============================================================================
// A request transaction is taken when start is high and busy is low, and
// exactly one result follows: it sits on the o_status, o_frame_length,
// o_byte_out and o_last_byte ports for one clock cycle, marked by o_done.
// The receiver cannot stall, so it must take the result in that cycle.
// Write begin, write byte, read end, unused request codes, a write end with
// no open frame, a read begin on an empty buffer and a read byte with
// nothing left are answered straight from decode. A write end on an open
// frame also passes through S_WEND_SUM because the single write port of the
// frame store stores the length byte and the checksum one after the other.
// A read begin that finds a frame and a read byte that has bytes left also
// pass through S_RBEGIN_FIN or S_RBYTE_FIN because the frame store read is
// registered. busy stays high until the cycle in which o_done is shown, so
// the next transaction can be started in that same cycle. No clearing pass
// follows reset: the frame store is only ever read at entries that a
// committed frame has written.
module framed_message_ring_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_data_in,
    input  logic       i_is_text,
    output logic       o_done,
    output logic [1:0] o_status,
    output logic [5:0] o_frame_length,
    output logic [7:0] o_byte_out,
    output logic       o_last_byte
);

    // Command and status groups between the sequencer and the datapath.
    fmrb_pkg::t_cmd   cmd;
    fmrb_pkg::t_flags flags;

    // The sequencer decides what each request does from the datapath flags
    // (room left, frame open, data limit reached, buffer empty, bytes left).
    fmrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_flags (flags),
        .o_cmd   (cmd)
    );

    // The datapath holds the frame store, the pointers, the running checksum
    // and the registered result fields.
    fmrb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_data_in      (i_data_in),
        .i_is_text      (i_is_text),
        .i_cmd          (cmd),
        .o_flags        (flags),
        .o_status       (o_status),
        .o_frame_length (o_frame_length),
        .o_byte_out     (o_byte_out),
        .o_last_byte    (o_last_byte)
    );

endmodule

### tb/fmrb_frame_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// fmrb_frame_monitor
// Watches the request and result ports of the framed message ring buffer,
// predicts every result from its own copy of the ring and compares them.
// ============================================================================
module fmrb_frame_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_data_in,
    input  logic       i_is_text,
    input  logic       o_done,
    input  logic [1:0] o_status,
    input  logic [5:0] o_frame_length,
    input  logic [7:0] o_byte_out,
    input  logic       o_last_byte,
    output int         mismatches,
    output int         pending
);

    typedef struct packed {
        fmrb_pkg::t_status status;
        logic [5:0]        length;
        logic [7:0]        value;
        logic              last;
    } t_response;

    // Shadow copy of the ring and of its pointers.
    logic [7:0]      ring_bytes [0:fmrb_pkg::BUF_DEPTH-1];
    fmrb_pkg::t_addr next_frame_slot;
    fmrb_pkg::t_addr fill_slot;
    int              fill_count;
    logic [7:0]      fill_sum;
    logic            frame_open;
    fmrb_pkg::t_addr freed_up_to;
    fmrb_pkg::t_addr drain_slot;
    int              drain_left;

    t_response  responses_due [$];

    function automatic fmrb_pkg::t_addr slot_after(input fmrb_pkg::t_addr p, input int n);
        return fmrb_pkg::t_addr'((int'(p) + n) % fmrb_pkg::BUF_DEPTH);
    endfunction

    function automatic int ring_gap(input fmrb_pkg::t_addr from,
                                    input fmrb_pkg::t_addr to);
        return (int'(to) + fmrb_pkg::BUF_DEPTH - int'(from)) % fmrb_pkg::BUF_DEPTH;
    endfunction

    task automatic clear_ring();
        for (int k = 0; k < fmrb_pkg::BUF_DEPTH; k++) begin
            ring_bytes[k] = 8'd0;
        end
        next_frame_slot = slot_after(fmrb_pkg::t_addr'(0), 1);
        fill_slot       = '0;
        fill_count      = 0;
        fill_sum        = 8'd0;
        frame_open      = 1'b0;
        freed_up_to     = '0;
        drain_slot      = '0;
        drain_left      = 0;
    endtask

    function automatic t_response predict_response(input logic [2:0] req,
                                                   input logic [7:0] data,
                                                   input logic       text);
        t_response  r;
        logic [7:0] len_byte;
        r = '0;
        case (req)
            fmrb_pkg::REQ_WBEGIN: begin
                if (ring_gap(next_frame_slot, freed_up_to) < fmrb_pkg::MIN_FREE) begin
                    r.status   = fmrb_pkg::ST_FULL;
                    frame_open = 1'b0;
                end else begin
                    fill_slot  = slot_after(next_frame_slot, 1);
                    fill_count = 0;
                    fill_sum   = 8'd0;
                    frame_open = 1'b1;
                end
            end
            fmrb_pkg::REQ_WBYTE: begin
                if (!frame_open || fill_count >= fmrb_pkg::MAX_DATA) begin
                    r.status = fmrb_pkg::ST_DROP;
                end else begin
                    ring_bytes[fill_slot] = data;
                    fill_slot  = slot_after(fill_slot, 1);
                    fill_count = fill_count + 1;
                    fill_sum   = fill_sum + data;
                end
            end
            fmrb_pkg::REQ_WEND: begin
                if (!frame_open) begin
                    r.status = fmrb_pkg::ST_EMPTY;
                end else begin
                    len_byte = {text, 7'(fill_count)};
                    ring_bytes[next_frame_slot] = len_byte;
                    fill_sum = fill_sum + len_byte;
                    // The checksum makes the whole frame sum to zero.
                    ring_bytes[fill_slot] = 8'd0 - fill_sum;
                    next_frame_slot = slot_after(fill_slot, 1);
                    frame_open = 1'b0;
                end
            end
            fmrb_pkg::REQ_RBEGIN: begin
                if (ring_gap(freed_up_to, next_frame_slot) <= 1) begin
                    r.status = fmrb_pkg::ST_EMPTY;
                end else begin
                    drain_slot = slot_after(freed_up_to, 1);
                    drain_left = int'(ring_bytes[drain_slot] & 8'(fmrb_pkg::MAX_DATA))
                               + fmrb_pkg::FRAME_EXTRA;
                    r.length   = 6'(drain_left);
                end
            end
            fmrb_pkg::REQ_RBYTE: begin
                if (drain_left == 0) begin
                    r.status = fmrb_pkg::ST_EMPTY;
                end else begin
                    r.value    = ring_bytes[drain_slot];
                    drain_left = drain_left - 1;
                    if (drain_left != 0) begin
                        drain_slot = slot_after(drain_slot, 1);
                    end else begin
                        r.last = 1'b1;
                    end
                end
            end
            fmrb_pkg::REQ_REND: begin
                if (drain_left != 0) begin
                    drain_slot = slot_after(drain_slot, drain_left - 1);
                    drain_left = 0;
                end
                freed_up_to = drain_slot;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_response due;
        if (!i_rst_n) begin
            clear_ring();
            responses_due.delete();
        end else begin
            // Results are retired before a new request is added, since both
            // can happen at the same edge.
            if (o_done === 1'b1) begin
                if (responses_due.size() == 0) begin
                    report_mismatch("result with no request waiting", 8'(o_status), 8'd0);
                end else begin
                    due = responses_due.pop_front();
                    if (o_status !== due.status)
                        report_mismatch("status", 8'(o_status), 8'(due.status));
                    if (o_frame_length !== due.length)
                        report_mismatch("frame_length", 8'(o_frame_length), 8'(due.length));
                    if (o_byte_out !== due.value)
                        report_mismatch("byte_out", o_byte_out, due.value);
                    if (o_last_byte !== due.last)
                        report_mismatch("last_byte", 8'(o_last_byte), 8'(due.last));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                responses_due.push_back(predict_response(i_req_type, i_data_in, i_is_text));
            end
        end
        pending <= responses_due.size();
    end

endmodule

### tb/framed_message_ring_buffer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// framed_message_ring_buffer_tb
// Drives request transactions into the framed message ring buffer: a short
// directed pass over the corner cases, then random frame traffic that fills
// the ring, mixes reads and writes and drains it again. A separate monitor
// predicts and checks every result; this module gives the verdict.
// ============================================================================
module framed_message_ring_buffer_tb;

    // Request codes the block does not decode; they must be answered with an
    // all-zero ok result.
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 1750;
    // Cycles without an accepted transaction or a shown result before the run
    // is abandoned; a correct block never comes near this limit.
    localparam int STALL_LIMIT  = 500;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] i_req_type = 3'd0;
    logic [7:0] i_data_in = 8'd0;
    logic       i_is_text = 1'b0;
    logic       busy;
    logic       o_done;
    logic [1:0] o_status;
    logic [5:0] o_frame_length;
    logic [7:0] o_byte_out;
    logic       o_last_byte;

    int mismatches;
    int pending;
    int sent_count = 0;
    int idle_pct = 17;
    int full_hits = 0;
    int stall_cycles = 0;

    always #6 i_clk = ~i_clk;

    framed_message_ring_buffer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_data_in      (i_data_in),
        .i_is_text      (i_is_text),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_frame_length (o_frame_length),
        .o_byte_out     (o_byte_out),
        .o_last_byte    (o_last_byte)
    );

    fmrb_frame_monitor frame_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_data_in      (i_data_in),
        .i_is_text      (i_is_text),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_frame_length (o_frame_length),
        .o_byte_out     (o_byte_out),
        .o_last_byte    (o_last_byte),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // Counts refused write begins so that the fill phase knows when the ring
    // has run out of room. Updated with a nonblocking assignment so the
    // stimulus always sees the value from before the current edge.
    always @(posedge i_clk) begin
        if (o_done === 1'b1 && o_status == fmrb_pkg::ST_FULL) begin
            full_hits <= full_hits + 1;
        end
    end

    // Watchdog: any accepted request or shown result counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("framed_message_ring_buffer_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Presents one request and returns at the edge that accepts it. start is
    // left high, so a following call keeps the request stream back to back
    // unless the random idle draw drops start in between.
    task automatic issue_request(input logic [2:0] req, input logic [7:0] data,
                                 input logic text);
        int gap;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= req;
        i_data_in  <= data;
        i_is_text  <= text;
        do @(posedge i_clk); while (busy !== 1'b0);
        sent_count++;
    endtask

    // Called right after a read begin was accepted: waits for its result and
    // returns the frame length that the block reported.
    task automatic await_length(output int len);
        start <= 1'b0;
        do @(posedge i_clk); while (o_done !== 1'b1);
        len = int'(o_frame_length);
    endtask

    // Holds the request side off until every outstanding result has come.
    task automatic wait_for_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_noise();
        issue_request(3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom));
    endtask

    // One write transaction sequence. Most frames are committed; a few are
    // restarted with a second write begin or left open, which the next write
    // begin then discards. Byte counts above 31 exercise the overflow drop.
    task automatic write_frame(input int n_bytes);
        int shape;
        shape = $urandom_range(99, 0);
        issue_request(fmrb_pkg::REQ_WBEGIN, 8'($urandom), 1'($urandom));
        if (shape < 5) begin
            issue_request(fmrb_pkg::REQ_WBYTE, 8'($urandom), 1'($urandom));
            issue_request(fmrb_pkg::REQ_WBEGIN, 8'($urandom), 1'($urandom));
        end
        for (int k = 0; k < n_bytes; k++) begin
            issue_request(fmrb_pkg::REQ_WBYTE, 8'($urandom), 1'($urandom));
        end
        if (shape >= 8) begin
            issue_request(fmrb_pkg::REQ_WEND, 8'($urandom), 1'($urandom));
        end
    endtask

    // One read transaction sequence, shaped by the length that read begin
    // returns: full reads, early frees, restarts, reads past the checksum,
    // and now and then no read end at all so the next read begin restarts.
    task automatic read_frame(output int first_len);
        int shape;
        int len;
        int upto;
        shape = $urandom_range(99, 0);
        issue_request(fmrb_pkg::REQ_RBEGIN, 8'($urandom), 1'($urandom));
        await_length(len);
        first_len = len;
        if (shape < 25) begin
            upto = 0;
        end else if (shape < 40) begin
            upto = $urandom_range(len, 0);
            for (int k = 0; k < upto; k++) begin
                issue_request(fmrb_pkg::REQ_RBYTE, 8'($urandom), 1'($urandom));
            end
            issue_request(fmrb_pkg::REQ_RBEGIN, 8'($urandom), 1'($urandom));
            await_length(len);
            upto = len;
        end else if (shape < 55) begin
            upto = len + $urandom_range(2, 1);
        end else begin
            upto = len;
        end
        for (int k = 0; k < upto; k++) begin
            issue_request(fmrb_pkg::REQ_RBYTE, 8'($urandom), 1'($urandom));
        end
        if (shape % 10 != 9) begin
            issue_request(fmrb_pkg::REQ_REND, 8'($urandom), 1'($urandom));
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 15) return $urandom_range(35, 32);
        if (r < 40) return $urandom_range(3, 0);
        return $urandom_range(31, 4);
    endfunction

    initial begin : stimulus
        int base;
        int mark;
        int mode;
        int phase;
        int new_phase;
        int hits_at_start;
        int len;
        int r;
        bit empty_seen;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------------------------------------------------------
        // Directed part.
        // ---------------------------------------------------------------
        // Undecoded request codes, with every other field at its maximum.
        issue_request(REQ_SPARE_A, 8'hFF, 1'b1);
        issue_request(REQ_SPARE_B, 8'hFF, 1'b1);
        // Every request but write begin on an empty ring with no frame open.
        issue_request(fmrb_pkg::REQ_RBEGIN, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_RBYTE, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_REND, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_WBYTE, 8'h5A, 1'b0);
        issue_request(fmrb_pkg::REQ_WEND, 8'h00, 1'b1);
        // A frame that is restarted by a second write begin, then committed
        // as a text frame with two data bytes.
        issue_request(fmrb_pkg::REQ_WBEGIN, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_WBYTE, 8'hFF, 1'b0);
        issue_request(fmrb_pkg::REQ_WBYTE, 8'h00, 1'b1);
        issue_request(fmrb_pkg::REQ_WBEGIN, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_WBYTE, 8'hA5, 1'b0);
        issue_request(fmrb_pkg::REQ_WBYTE, 8'h80, 1'b0);
        issue_request(fmrb_pkg::REQ_WEND, 8'h00, 1'b1);
        // Read one byte, restart, read the whole frame and one byte past it.
        issue_request(fmrb_pkg::REQ_RBEGIN, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_RBYTE, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_RBEGIN, 8'h00, 1'b0);
        repeat (4) issue_request(fmrb_pkg::REQ_RBYTE, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_RBYTE, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_REND, 8'h00, 1'b0);
        // A frame with no data, freed before any byte of it is read.
        issue_request(fmrb_pkg::REQ_WBEGIN, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_WEND, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_RBEGIN, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_REND, 8'h00, 1'b0);
        issue_request(fmrb_pkg::REQ_RBEGIN, 8'h00, 1'b0);

        // ---------------------------------------------------------------
        // Random part. Traffic rotates through four modes: fill the ring
        // with long frames until a write begin is refused, mixed traffic,
        // drain until a read begin finds the ring empty, mixed again. The
        // idle rate of the request side steps from 17 to 48 to 0 percent
        // over the run, and the request side pauses for all outstanding
        // results at every step.
        // ---------------------------------------------------------------
        base  = sent_count;
        phase = 0;
        mode  = 0;
        while (sent_count - base < RANDOM_ITEMS) begin
            new_phase = (sent_count - base) * 3 / RANDOM_ITEMS;
            if (new_phase != phase) begin
                phase = new_phase;
                wait_for_quiet();
                idle_pct = (phase == 1) ? 48 : 0;
            end
            mark = sent_count;
            case (mode)
                0: begin
                    hits_at_start = full_hits;
                    while (full_hits == hits_at_start && sent_count - mark < 700) begin
                        if ($urandom_range(9, 0) == 0) begin
                            send_noise();
                        end else begin
                            write_frame($urandom_range(35, 24));
                        end
                    end
                    // A few more attempts while the ring is still full.
                    write_frame($urandom_range(3, 0));
                end
                2: begin
                    empty_seen = 1'b0;
                    while (!empty_seen && sent_count - mark < 400) begin
                        r = $urandom_range(99, 0);
                        if (r < 85) begin
                            read_frame(len);
                            empty_seen = (len == 0);
                        end else if (r < 93) begin
                            write_frame(pick_length());
                        end else begin
                            send_noise();
                        end
                    end
                end
                default: begin
                    while (sent_count - mark < 300) begin
                        r = $urandom_range(99, 0);
                        if (r < 50) begin
                            write_frame(pick_length());
                        end else if (r < 85) begin
                            read_frame(len);
                        end else begin
                            repeat ($urandom_range(3, 1)) send_noise();
                        end
                    end
                end
            endcase
            mode = (mode + 1) % 4;
        end

        // Let the last results arrive, then idle on so that a stray result would
        // still be caught.
        wait_for_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("framed_message_ring_buffer_tb OK");
        end else begin
            $display("framed_message_ring_buffer_tb NOT OK");
        end
        $finish;
    end

endmodule
